// File: hdl/drl_pkg.sv
// Package for the dense ReLU training layer: widths, command and result codes,
// payload structs and the Q16.16 to Q8.8 rounding function.
// No dependencies; every other file of the block uses it by scoped names.
package drl_pkg;

  localparam int MAX_INPUTS_DEF  = 16;
  localparam int MAX_OUTPUTS_DEF = 16;
  localparam int VALUE_W    = 16;
  localparam int ACC_W      = 32;
  localparam int LR_W       = 16;
  localparam int MB_W       = LR_W + 1;
  localparam int CNT_REG_W  = 5;
  localparam int IDX_W      = 4;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;
  localparam int STEP_SHIFT = 24;

  localparam logic [LR_W-1:0]      LR_RESET    = 16'd655;
  localparam logic [CNT_REG_W-1:0] COUNT_RESET = 5'd16;

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0]   ACC_MAX   = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0]   ACC_MIN   = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [2:0] {
    CMD_WR_WEIGHT = 3'd0,
    CMD_WR_BIAS   = 3'd1,
    CMD_FWD_ELEM  = 3'd2,
    CMD_BWD_ELEM  = 3'd3,
    CMD_UPDATE    = 3'd4,
    CMD_ZERO_GRAD = 3'd5,
    CMD_RD_WEIGHT = 3'd6,
    CMD_RD_BIAS   = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ACT  = 2'd0,
    KIND_GRAD = 2'd1,
    KIND_READ = 2'd2
  } kind_t;

  typedef enum logic {
    OP_ACC  = 1'b0,
    OP_STEP = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_LR      = 2'd0,
    REG_IN_CNT  = 2'd1,
    REG_OUT_CNT = 2'd2
  } reg_t;

  typedef struct packed {
    cmd_t                      cmd;
    logic [IDX_W-1:0]          row_index;
    logic [IDX_W-1:0]          col_index;
    logic signed [VALUE_W-1:0] data_value;
    logic                      in_last;
  } in_t;

  typedef struct packed {
    kind_t                     result_kind;
    logic [IDX_W-1:0]          result_index;
    logic signed [VALUE_W-1:0] result_value;
    logic                      out_last;
  } out_t;

  // Round a Q16.16 accumulator to Q8.8: add one half, floor shift, saturate.
  function automatic logic signed [VALUE_W-1:0] to_value(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W+1:0] t;
    t = (ACC_W+2)'(v);
    t = t + (ACC_W+2)'(128);
    t = t >>> 8;
    if (t > (ACC_W+2)'(VALUE_MAX)) begin
      to_value = VALUE_MAX;
    end else if (t < (ACC_W+2)'(VALUE_MIN)) begin
      to_value = VALUE_MIN;
    end else begin
      to_value = t[VALUE_W-1:0];
    end
  endfunction

endpackage

// File: hdl/drl_if.sv
// Channel interfaces of the dense ReLU training layer: command items in,
// result items out, each with valid/ready. Depends on drl_pkg.
interface drl_in_if;
  logic         valid;
  logic         ready;
  drl_pkg::in_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface drl_out_if;
  logic          valid;
  logic          ready;
  drl_pkg::out_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: hdl/dense_relu_layer_train.sv
// Top level of the dense ReLU training layer: sequencer, weight and gradient
// memories, APB register file. Depends on drl_pkg, drl_if and drl_mac.
//
// Usage. Command items arrive on in_ch (valid/ready); a transfer takes place
// when both are high. Results leave on out_ch through an output register, so
// the layer keeps working while a finished result waits to be taken. The APB
// port sets the learning rate and the input and output counts; write it only
// while the layer is idle.
// Sequencing. Weight, bias and non-last forward elements are handled in the
// idle state. The last forward element walks the weight matrix through the
// shared multiply-accumulate unit, output by output. A last backward element
// then walks every entry of the input-gradient memory (MAX_INPUTS): the
// entries in use are emitted and all of them are cleared. Update walks each
// output row. Each step is bound by the registered memory read and the
// two-stage multiply unit, of which there is one.
// Reset and stalls. After reset, and after a zero-grad command, a clearing
// pass over all MAX_INPUTS*MAX_OUTPUTS entries (256 by default) zeroes the
// weight and bias gradient memories, and after reset also the input-gradient
// memory; no item is accepted meanwhile. If the receiver stalls, the
// sequencer holds at the pending result without losing anything.
module dense_relu_layer_train #(
  parameter int MAX_INPUTS  = drl_pkg::MAX_INPUTS_DEF,
  parameter int MAX_OUTPUTS = drl_pkg::MAX_OUTPUTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  drl_in_if.sink                         in_ch,
  drl_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [drl_pkg::PADDR_W-1:0]    paddr,
  input  logic [drl_pkg::PDATA_W-1:0]    pwdata,
  output logic [drl_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);
  localparam int VW    = drl_pkg::VALUE_W;
  localparam int AW    = drl_pkg::ACC_W;
  localparam int MBW   = drl_pkg::MB_W;
  localparam int IW    = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int OW    = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int DEPTH = MAX_INPUTS * MAX_OUTPUTS;
  localparam int WAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = 8;

  // One-hot sequencer states.
  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_ZRD   = 11'b00000000100,
    S_ZCHK  = 11'b00000001000,
    S_RD    = 11'b00000010000,
    S_MUL   = 11'b00000100000,
    S_MUL2  = 11'b00001000000,
    S_WAIT  = 11'b00010000000,
    S_WB    = 11'b00100000000,
    S_WB2   = 11'b01000000000,
    S_EMIT  = 11'b10000000000
  } state_t;

  typedef enum logic [2:0] {
    MODE_FWD   = 3'd0,
    MODE_BWD   = 3'd1,
    MODE_GEMIT = 3'd2,
    MODE_UPD   = 3'd3,
    MODE_READW = 3'd4,
    MODE_READB = 3'd5
  } mode_t;

  state_t state;
  mode_t  mode;
  logic [OW-1:0]  i;
  logic [IW-1:0]  j;
  logic           bphase;
  logic           last_r;
  logic           clr_all;
  logic [WAW-1:0] cnt;
  logic signed [VW-1:0] g_r;
  logic signed [VW-1:0] delta;
  logic signed [AW-1:0] sum;
  logic [drl_pkg::IDX_W-1:0] ridx;

  logic [drl_pkg::LR_W-1:0]      lr;
  logic [drl_pkg::CNT_REG_W-1:0] in_cnt;
  logic [drl_pkg::CNT_REG_W-1:0] out_cnt;

  logic          out_valid;
  drl_pkg::out_t out_data;
  drl_pkg::out_t em;
  logic          out_free;
  logic          g_emit;
  logic          emit_go;

  // Memories and their registered read data.
  logic signed [VW-1:0] wmem  [DEPTH];
  logic signed [VW-1:0] bmem  [MAX_OUTPUTS];
  logic signed [VW-1:0] xmem  [MAX_INPUTS];
  logic signed [VW-1:0] zmem  [MAX_OUTPUTS];
  logic signed [AW-1:0] wgmem [DEPTH];
  logic signed [AW-1:0] bgmem [MAX_OUTPUTS];
  logic signed [AW-1:0] gmem  [MAX_INPUTS];
  logic signed [VW-1:0] w_rd, b_rd, x_rd, z_rd;
  logic signed [AW-1:0] wg_rd, bg_rd, g_rd;

  logic                 w_we, b_we, x_we, z_we, g_we, wg_we, bg_we;
  logic [WAW-1:0]       w_wa, wg_wa;
  logic [OW-1:0]        b_wa, bg_wa;
  logic [IW-1:0]        x_wa, g_wa;
  logic signed [VW-1:0] w_wd, b_wd, x_wd, z_wd;
  logic signed [AW-1:0] g_wd, wg_wd, bg_wd;

  logic [CW-1:0]  ni_u, no_u, ni_t, no_t;
  logic [IW-1:0]  ni_m1;
  logic [OW-1:0]  no_m1;
  logic           in_acc;
  logic           cfg_we;
  drl_pkg::reg_t  cfg_idx;
  logic [OW-1:0]  in_row_w;
  logic [IW-1:0]  in_col_w;
  logic           row_ok;
  logic [WAW-1:0] w_addr, in_waddr;
  logic           cnt_in_i, cnt_in_o;
  logic signed [VW-1:0] z_val;
  logic [CW-1:0]  i_ext, j_ext;

  drl_pkg::op_t         u_op;
  logic signed [AW-1:0]  u_a, u_acc, u_res;
  logic signed [MBW-1:0] u_b;

  // Indices beyond the stores wrap modulo the store dimension.
  function automatic logic [OW-1:0] wrap_row(input logic [drl_pkg::IDX_W-1:0] idx);
    logic [OW-1:0] r;
    r = '0;
    for (int k = 0; k < 2 ** drl_pkg::IDX_W; k++) begin
      if (idx == drl_pkg::IDX_W'(k)) r = OW'(k % MAX_OUTPUTS);
    end
    return r;
  endfunction

  function automatic logic [IW-1:0] wrap_col(input logic [drl_pkg::IDX_W-1:0] idx);
    logic [IW-1:0] r;
    r = '0;
    for (int k = 0; k < 2 ** drl_pkg::IDX_W; k++) begin
      if (idx == drl_pkg::IDX_W'(k)) r = IW'(k % MAX_INPUTS);
    end
    return r;
  endfunction

  // Counts in use: zero acts as one, large values clamp to the store size.
  always_comb begin
    if (in_cnt == '0) begin
      ni_u = CW'(1);
    end else if (CW'(in_cnt) > CW'(MAX_INPUTS)) begin
      ni_u = CW'(MAX_INPUTS);
    end else begin
      ni_u = CW'(in_cnt);
    end
    if (out_cnt == '0) begin
      no_u = CW'(1);
    end else if (CW'(out_cnt) > CW'(MAX_OUTPUTS)) begin
      no_u = CW'(MAX_OUTPUTS);
    end else begin
      no_u = CW'(out_cnt);
    end
    ni_t  = ni_u - CW'(1);
    no_t  = no_u - CW'(1);
    ni_m1 = ni_t[IW-1:0];
    no_m1 = no_t[OW-1:0];
  end

  assign in_ch.ready = (state == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_row_w    = wrap_row(in_ch.data.row_index);
  assign in_col_w    = wrap_col(in_ch.data.col_index);
  assign row_ok      = CW'(in_ch.data.row_index) < no_u;
  assign w_addr      = WAW'(i) * WAW'(MAX_INPUTS) + WAW'(j);
  assign in_waddr    = WAW'(in_row_w) * WAW'(MAX_INPUTS) + WAW'(in_col_w);
  assign cnt_in_i    = (WAW + 1)'(cnt) < (WAW + 1)'(MAX_INPUTS);
  assign cnt_in_o    = (WAW + 1)'(cnt) < (WAW + 1)'(MAX_OUTPUTS);
  assign z_val       = drl_pkg::to_value(sum);
  assign out_free    = !out_valid || out_ch.ready;
  assign i_ext       = CW'(i);
  assign j_ext       = CW'(j);

  // The gradient emit walks every entry of the input-gradient memory so that
  // all of them are cleared; only the entries in use produce a result.
  assign g_emit  = j_ext < ni_u;
  assign emit_go = (state == S_EMIT) && out_free && (mode != MODE_GEMIT || g_emit);

  // Configuration registers.
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = drl_pkg::reg_t'(paddr[drl_pkg::PADDR_W-1:2]);

  always_comb begin
    case (cfg_idx)
      drl_pkg::REG_LR:      prdata = drl_pkg::PDATA_W'(lr);
      drl_pkg::REG_IN_CNT:  prdata = drl_pkg::PDATA_W'(in_cnt);
      drl_pkg::REG_OUT_CNT: prdata = drl_pkg::PDATA_W'(out_cnt);
      default:              prdata = '0;
    endcase
  end

  // Memory write ports: one per memory, selected by the sequencer.
  always_comb begin
    w_we = 1'b0;  w_wa = w_addr;    w_wd = u_res[VW-1:0];
    b_we = 1'b0;  b_wa = i;         b_wd = u_res[VW-1:0];
    x_we = 1'b0;  x_wa = in_col_w;  x_wd = in_ch.data.data_value;
    z_we = 1'b0;                    z_wd = z_val;
    g_we = 1'b0;  g_wa = j;         g_wd = u_res;
    wg_we = 1'b0; wg_wa = w_addr;   wg_wd = u_res;
    bg_we = 1'b0; bg_wa = i;        bg_wd = u_res;

    if (in_acc && in_ch.data.cmd == drl_pkg::CMD_WR_WEIGHT) begin
      w_we = 1'b1;
      w_wa = in_waddr;
      w_wd = in_ch.data.data_value;
    end
    if (in_acc && in_ch.data.cmd == drl_pkg::CMD_WR_BIAS) begin
      b_we = 1'b1;
      b_wa = in_row_w;
      b_wd = in_ch.data.data_value;
    end
    if (in_acc && in_ch.data.cmd == drl_pkg::CMD_FWD_ELEM) begin
      x_we = 1'b1;
    end

    case (state)
      S_WB: begin
        if (mode == MODE_UPD) begin
          w_we = !bphase;
          b_we = bphase;
        end
        if (mode == MODE_BWD) begin
          g_we  = !bphase;
          bg_we = bphase;
        end
      end
      S_WB2: wg_we = 1'b1;
      S_EMIT: begin
        if (out_free && mode == MODE_FWD) begin
          z_we = 1'b1;
        end
        if (mode == MODE_GEMIT && (emit_go || !g_emit)) begin
          g_we = 1'b1;
          g_wd = '0;
        end
      end
      S_CLEAR: begin
        wg_we = 1'b1;
        wg_wa = cnt;
        wg_wd = '0;
        bg_we = cnt_in_o;
        bg_wa = cnt[OW-1:0];
        bg_wd = '0;
        if (clr_all) begin
          g_we = cnt_in_i;
          g_wa = cnt[IW-1:0];
          g_wd = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (w_we) wmem[w_wa] <= w_wd;
    w_rd <= wmem[w_addr];
  end

  always_ff @(posedge clk) begin
    if (b_we) bmem[b_wa] <= b_wd;
    b_rd <= bmem[i];
  end

  always_ff @(posedge clk) begin
    if (x_we) xmem[x_wa] <= x_wd;
    x_rd <= xmem[j];
  end

  always_ff @(posedge clk) begin
    if (z_we) zmem[i] <= z_wd;
    z_rd <= zmem[i];
  end

  always_ff @(posedge clk) begin
    if (g_we) gmem[g_wa] <= g_wd;
    g_rd <= gmem[j];
  end

  always_ff @(posedge clk) begin
    if (wg_we) wgmem[wg_wa] <= wg_wd;
    wg_rd <= wgmem[w_addr];
  end

  always_ff @(posedge clk) begin
    if (bg_we) bgmem[bg_wa] <= bg_wd;
    bg_rd <= bgmem[i];
  end

  // Operand selection for the shared unit. A backward step issues two
  // operations back to back: input gradient first, weight gradient second.
  always_comb begin
    u_op  = drl_pkg::OP_ACC;
    u_a   = AW'(w_rd);
    u_b   = MBW'(x_rd);
    u_acc = sum;
    case (mode)
      MODE_FWD: begin
        if (bphase) begin
          u_a   = AW'(b_rd);
          u_b   = MBW'(256);
          u_acc = '0;
        end
      end
      MODE_BWD: begin
        if (bphase) begin
          u_a   = AW'(delta);
          u_b   = MBW'(256);
          u_acc = bg_rd;
        end else if (state == S_MUL2) begin
          u_a   = AW'(x_rd);
          u_b   = MBW'(delta);
          u_acc = wg_rd;
        end else begin
          u_a   = AW'(w_rd);
          u_b   = MBW'(delta);
          u_acc = g_rd;
        end
      end
      MODE_UPD: begin
        u_op = drl_pkg::OP_STEP;
        u_b  = {1'b0, lr};
        if (bphase) begin
          u_a   = bg_rd;
          u_acc = AW'(b_rd);
        end else begin
          u_a   = wg_rd;
          u_acc = AW'(w_rd);
        end
      end
      default: ;
    endcase
  end

  drl_mac u_mac (
    .clk (clk),
    .op  (u_op),
    .a   (u_a),
    .b   (u_b),
    .acc (u_acc),
    .res (u_res)
  );

  // Result assembled in the emit state.
  always_comb begin
    em.result_kind  = drl_pkg::KIND_READ;
    em.result_index = ridx;
    em.result_value = w_rd;
    em.out_last     = 1'b1;
    case (mode)
      MODE_FWD: begin
        em.result_kind  = drl_pkg::KIND_ACT;
        em.result_index = i_ext[drl_pkg::IDX_W-1:0];
        em.result_value = (z_val > 0) ? z_val : '0;
        em.out_last     = (i == no_m1);
      end
      MODE_GEMIT: begin
        em.result_kind  = drl_pkg::KIND_GRAD;
        em.result_index = j_ext[drl_pkg::IDX_W-1:0];
        em.result_value = drl_pkg::to_value(g_rd);
        em.out_last     = (j == ni_m1);
      end
      MODE_READB: em.result_value = b_rd;
      default: ;
    endcase
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      mode      <= MODE_FWD;
      clr_all   <= 1'b1;
      cnt       <= '0;
      i         <= '0;
      j         <= '0;
      bphase    <= 1'b0;
      out_valid <= 1'b0;
      lr        <= drl_pkg::LR_RESET;
      in_cnt    <= drl_pkg::COUNT_RESET;
      out_cnt   <= drl_pkg::COUNT_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          drl_pkg::REG_LR:      lr      <= pwdata[drl_pkg::LR_W-1:0];
          drl_pkg::REG_IN_CNT:  in_cnt  <= pwdata[drl_pkg::CNT_REG_W-1:0];
          drl_pkg::REG_OUT_CNT: out_cnt <= pwdata[drl_pkg::CNT_REG_W-1:0];
          default: ;
        endcase
      end

      if (out_ch.ready && !emit_go) out_valid <= 1'b0;

      case (state)
        S_CLEAR: begin
          cnt <= cnt + WAW'(1);
          if (cnt == WAW'(DEPTH - 1)) begin
            state   <= S_IDLE;
            clr_all <= 1'b0;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            last_r <= in_ch.data.in_last;
            g_r    <= in_ch.data.data_value;
            case (in_ch.data.cmd)
              drl_pkg::CMD_FWD_ELEM: begin
                if (in_ch.data.in_last) begin
                  mode   <= MODE_FWD;
                  i      <= '0;
                  j      <= '0;
                  bphase <= 1'b1;
                  state  <= S_RD;
                end
              end
              drl_pkg::CMD_BWD_ELEM: begin
                i      <= in_row_w;
                j      <= '0;
                bphase <= 1'b0;
                if (row_ok) begin
                  mode  <= MODE_BWD;
                  state <= S_ZRD;
                end else if (in_ch.data.in_last) begin
                  mode  <= MODE_GEMIT;
                  state <= S_RD;
                end
              end
              drl_pkg::CMD_UPDATE: begin
                mode   <= MODE_UPD;
                i      <= '0;
                j      <= '0;
                bphase <= 1'b0;
                state  <= S_RD;
              end
              drl_pkg::CMD_ZERO_GRAD: begin
                cnt   <= '0;
                state <= S_CLEAR;
              end
              drl_pkg::CMD_RD_WEIGHT: begin
                i     <= in_row_w;
                j     <= in_col_w;
                ridx  <= in_ch.data.col_index;
                mode  <= MODE_READW;
                state <= S_RD;
              end
              drl_pkg::CMD_RD_BIAS: begin
                i     <= in_row_w;
                ridx  <= in_ch.data.row_index;
                mode  <= MODE_READB;
                state <= S_RD;
              end
              default: ;
            endcase
          end
        end
        S_ZRD: state <= S_ZCHK;
        S_ZCHK: begin
          // The gradient passes only where the kept pre-activation is positive.
          delta <= (z_rd > 0) ? g_r : '0;
          state <= S_RD;
        end
        S_RD: begin
          if (mode == MODE_READW || mode == MODE_READB || mode == MODE_GEMIT) begin
            state <= S_EMIT;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (mode == MODE_BWD && !bphase) begin
            state <= S_MUL2;
          end else begin
            state <= S_WAIT;
          end
        end
        S_MUL2: state <= S_WB;
        S_WAIT: state <= S_WB;
        S_WB: begin
          case (mode)
            MODE_FWD: begin
              sum <= u_res;
              if (bphase) begin
                bphase <= 1'b0;
                state  <= S_RD;
              end else if (j == ni_m1) begin
                state <= S_EMIT;
              end else begin
                j     <= j + IW'(1);
                state <= S_RD;
              end
            end
            MODE_BWD: begin
              if (!bphase) begin
                state <= S_WB2;
              end else if (last_r) begin
                mode  <= MODE_GEMIT;
                j     <= '0;
                state <= S_RD;
              end else begin
                state <= S_IDLE;
              end
            end
            MODE_UPD: begin
              if (!bphase) begin
                if (j == ni_m1) begin
                  bphase <= 1'b1;
                end else begin
                  j <= j + IW'(1);
                end
                state <= S_RD;
              end else begin
                bphase <= 1'b0;
                j      <= '0;
                if (i == no_m1) begin
                  state <= S_IDLE;
                end else begin
                  i     <= i + OW'(1);
                  state <= S_RD;
                end
              end
            end
            default: state <= S_IDLE;
          endcase
        end
        S_WB2: begin
          if (j == ni_m1) begin
            bphase <= 1'b1;
          end else begin
            j <= j + IW'(1);
          end
          state <= S_RD;
        end
        S_EMIT: begin
          if (mode == MODE_GEMIT && !g_emit) begin
            // An entry beyond the inputs in use is only cleared.
            if (j == IW'(MAX_INPUTS - 1)) begin
              state <= S_IDLE;
            end else begin
              j     <= j + IW'(1);
              state <= S_RD;
            end
          end else if (emit_go) begin
            out_valid <= 1'b1;
            out_data  <= em;
            case (mode)
              MODE_FWD: begin
                if (i == no_m1) begin
                  state <= S_IDLE;
                end else begin
                  i      <= i + OW'(1);
                  j      <= '0;
                  bphase <= 1'b1;
                  state  <= S_RD;
                end
              end
              MODE_GEMIT: begin
                if (j == IW'(MAX_INPUTS - 1)) begin
                  state <= S_IDLE;
                end else begin
                  j     <= j + IW'(1);
                  state <= S_RD;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: hdl/drl_mac.sv
// Shared two-stage arithmetic unit: registered multiply, then either a
// saturating accumulate or an SGD step with rounding. Depends on drl_pkg.
module drl_mac (
  input  logic                              clk,
  input  drl_pkg::op_t                      op,
  input  logic signed [drl_pkg::ACC_W-1:0]  a,
  input  logic signed [drl_pkg::MB_W-1:0]   b,
  input  logic signed [drl_pkg::ACC_W-1:0]  acc,
  output logic signed [drl_pkg::ACC_W-1:0]  res
);
  localparam int AW  = drl_pkg::ACC_W;
  localparam int VW  = drl_pkg::VALUE_W;
  localparam int P_W = drl_pkg::ACC_W + drl_pkg::MB_W;
  localparam int S_W = P_W + 1;

  logic signed [P_W-1:0] prod;
  logic signed [AW-1:0]  acc_s;
  drl_pkg::op_t          op_s;
  logic signed [S_W-1:0] sum;
  logic signed [S_W-1:0] step;
  logic signed [S_W-1:0] diff;
  logic signed [AW-1:0]  res_next;

  always_ff @(posedge clk) begin
    prod  <= a * b;
    acc_s <= acc;
    op_s  <= op;
    res   <= res_next;
  end

  always_comb begin
    sum  = S_W'(acc_s) + S_W'(prod);
    step = (S_W'(prod) + S_W'(2 ** (drl_pkg::STEP_SHIFT - 1))) >>> drl_pkg::STEP_SHIFT;
    diff = S_W'(acc_s) - step;
    res_next = '0;
    case (op_s)
      drl_pkg::OP_ACC: begin
        if (sum > S_W'(drl_pkg::ACC_MAX)) begin
          res_next = drl_pkg::ACC_MAX;
        end else if (sum < S_W'(drl_pkg::ACC_MIN)) begin
          res_next = drl_pkg::ACC_MIN;
        end else begin
          res_next = sum[AW-1:0];
        end
      end
      drl_pkg::OP_STEP: begin
        if (diff > S_W'(drl_pkg::VALUE_MAX)) begin
          res_next = AW'(drl_pkg::VALUE_MAX);
        end else if (diff < S_W'(drl_pkg::VALUE_MIN)) begin
          res_next = AW'(drl_pkg::VALUE_MIN);
        end else begin
          res_next = AW'($signed(diff[VW-1:0]));
        end
      end
      default: res_next = '0;
    endcase
  end
endmodule

// File: hdl/drl_chk.sv
// Port-level checker for the dense ReLU training layer, with the bind that
// attaches it to the top level. Depends on drl_pkg.
module drl_chk (
  input logic          clk,
  input logic          rst,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input drl_pkg::out_t out_data
);
  // A result held back by the receiver stays unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // The clearing pass follows reset, so no item is taken right after it.
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input ready during clearing pass");

  // A new result only appears while the layer is busy with an item.
  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while idle");

  // Every read-back is a run of one result.
  a_read_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.result_kind == drl_pkg::KIND_READ |-> out_data.out_last)
    else $error("read-back result without last mark");
endmodule

bind dense_relu_layer_train drl_chk u_drl_chk (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

// File: tb/dense_relu_layer_train_tb.sv
// Testbench for the dense ReLU training layer: random and directed command streams
// are checked against a built-in fixed-point layer model held in a scoreboard.
// Depends on drl_pkg, drl_if and the RTL of dense_relu_layer_train.
`timescale 1ns / 1ps

// Holds a copy of the layer's state and the queue of results still to arrive.
class layer_scoreboard;
  longint weight[16][16];
  longint bias[16];
  longint weight_grad[16][16];
  longint bias_grad[16];
  longint inputs[16];
  longint preact[16];
  longint in_grad[16];
  longint rate;
  int in_reg;
  int out_reg;
  drl_pkg::out_t pending[$];
  int errors;

  function new();
    rate = 655;
    in_reg = 16;
    out_reg = 16;
    errors = 0;
    foreach (weight_grad[i, j]) weight_grad[i][j] = 0;
    foreach (bias_grad[i]) bias_grad[i] = 0;
    foreach (in_grad[i]) in_grad[i] = 0;
  endfunction

  function longint sat(longint v, int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Q16.16 to Q8.8: add half an LSB, floor shift, saturate.
  function longint to_q88(longint v);
    return sat((v + 128) >>> 8, 16);
  endfunction

  function int in_use();
    if (in_reg == 0) return 1;
    return (in_reg > 16) ? 16 : in_reg;
  endfunction

  function int out_use();
    if (out_reg == 0) return 1;
    return (out_reg > 16) ? 16 : out_reg;
  endfunction

  function void predict(drl_pkg::kind_t kind, int idx, longint v, bit last);
    drl_pkg::out_t r;
    r.result_kind = kind;
    r.result_index = idx[3:0];
    r.result_value = v[15:0];
    r.out_last = last;
    pending.push_back(r);
  endfunction

  // Called once per accepted command transfer.
  function void note_command(drl_pkg::in_t it);
    int row;
    int col;
    int ni;
    int no;
    longint d;
    longint acc;
    longint z;
    longint delta;
    row = it.row_index;
    col = it.col_index;
    d = longint'(it.data_value);
    ni = in_use();
    no = out_use();
    case (it.cmd)
      drl_pkg::CMD_WR_WEIGHT: weight[row][col] = d;
      drl_pkg::CMD_WR_BIAS: bias[row] = d;
      drl_pkg::CMD_FWD_ELEM: begin
        inputs[col] = d;
        if (it.in_last) begin
          for (int i = 0; i < no; i++) begin
            acc = bias[i] * 256;
            for (int j = 0; j < ni; j++) acc = sat(acc + weight[i][j] * inputs[j], 32);
            z = to_q88(acc);
            preact[i] = z;
            predict(drl_pkg::KIND_ACT, i, (z > 0) ? z : 0, i + 1 == no);
          end
        end
      end
      drl_pkg::CMD_BWD_ELEM: begin
        if (row < no) begin
          delta = (preact[row] > 0) ? d : 0;
          for (int j = 0; j < ni; j++) begin
            in_grad[j] = sat(in_grad[j] + weight[row][j] * delta, 32);
            weight_grad[row][j] = sat(weight_grad[row][j] + delta * inputs[j], 32);
          end
          bias_grad[row] = sat(bias_grad[row] + delta * 256, 32);
        end
        if (it.in_last) begin
          for (int j = 0; j < ni; j++)
            predict(drl_pkg::KIND_GRAD, j, to_q88(in_grad[j]), j + 1 == ni);
          foreach (in_grad[j]) in_grad[j] = 0;
        end
      end
      drl_pkg::CMD_UPDATE: begin
        // SGD step: gradient times rate is Q16.32, rounded back to Q8.8.
        for (int i = 0; i < no; i++) begin
          for (int j = 0; j < ni; j++)
            weight[i][j] = sat(weight[i][j] - ((weight_grad[i][j] * rate + (1 << 23)) >>> 24), 16);
          bias[i] = sat(bias[i] - ((bias_grad[i] * rate + (1 << 23)) >>> 24), 16);
        end
      end
      drl_pkg::CMD_ZERO_GRAD: begin
        foreach (weight_grad[i, j]) weight_grad[i][j] = 0;
        foreach (bias_grad[i]) bias_grad[i] = 0;
      end
      drl_pkg::CMD_RD_WEIGHT: predict(drl_pkg::KIND_READ, col, weight[row][col], 1'b1);
      default: predict(drl_pkg::KIND_READ, row, bias[row], 1'b1);
    endcase
  endfunction

  // Called once per accepted result transfer.
  function void check_result(drl_pkg::out_t got);
    drl_pkg::out_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %p", $time, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.result_kind !== want.result_kind) begin
      $display("%0t: result_kind mismatch, expected %0d, actual %0d", $time,
               want.result_kind, got.result_kind);
      errors++;
    end
    if (got.result_index !== want.result_index) begin
      $display("%0t: result_index mismatch, expected %0d, actual %0d", $time,
               want.result_index, got.result_index);
      errors++;
    end
    if (got.result_value !== want.result_value) begin
      $display("%0t: result_value mismatch, expected %0d, actual %0d", $time,
               want.result_value, got.result_value);
      errors++;
    end
    if (got.out_last !== want.out_last) begin
      $display("%0t: out_last mismatch, expected %0d, actual %0d", $time,
               want.out_last, got.out_last);
      errors++;
    end
  endfunction
endclass

module dense_relu_layer_train_tb;

  // The longest silent command is an update over 16 rows of 16 inputs, and
  // this settle time covers anything still in flight.
  localparam int SETTLE_CYCLES = 1200;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [drl_pkg::PADDR_W-1:0] paddr;
  logic [drl_pkg::PDATA_W-1:0] pwdata;
  logic [drl_pkg::PDATA_W-1:0] prdata;
  logic pready;

  drl_in_if in_ch();
  drl_out_if out_ch();

  layer_scoreboard sb;
  int sent;
  // When set, neither side inserts wait cycles, so back-to-back transfers occur.
  bit no_gaps;

  dense_relu_layer_train dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop in case the layer hangs; a correct run finishes far sooner.
  initial begin
    #50ms;
    $display("dense_relu_layer_train regression: fail");
    $finish;
  end

  function automatic int draw_gap();
    if (no_gaps) return 0;
    return $urandom_range(0, 15);
  endfunction

  // Mostly small Q8.8 values so sums stay in range; sometimes the full 16 bits.
  function automatic logic [15:0] pick_value();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 1023)) - 512);
  endfunction

  // Sends one command. Valid stays high into the next command when no gap is
  // drawn, so it is never lowered and raised again in the same step.
  task automatic send(drl_pkg::cmd_t c, int row, int col, logic [15:0] v, bit last);
    drl_pkg::in_t it;
    int gap;
    it.cmd = c;
    it.row_index = row[3:0];
    it.col_index = col[3:0];
    it.data_value = v;
    it.in_last = last;
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_command(it);
    sent++;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // A full input vector in order, optionally with a stray element past the
  // inputs in use, which the layer stores but ignores.
  task automatic send_forward_vector();
    int ni;
    ni = sb.in_use();
    if (ni < 16 && $urandom_range(0, 3) == 0)
      send(drl_pkg::CMD_FWD_ELEM, $urandom, 15, pick_value(), 1'b0);
    for (int j = 0; j < ni; j++)
      send(drl_pkg::CMD_FWD_ELEM, $urandom, j, pick_value(), j == ni - 1);
  endtask

  task automatic send_backward_vector();
    int n;
    int row;
    n = $urandom_range(1, sb.out_use() + 1);
    for (int k = 0; k < n; k++) begin
      row = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                        : $urandom_range(0, sb.out_use() - 1);
      send(drl_pkg::CMD_BWD_ELEM, row, $urandom, pick_value(), k == n - 1);
    end
  endtask

  task automatic send_random();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) send_forward_vector();
    else if (r < 60) send_backward_vector();
    else if (r < 70) send(drl_pkg::CMD_WR_WEIGHT, $urandom, $urandom, pick_value(), $urandom);
    else if (r < 75) send(drl_pkg::CMD_WR_BIAS, $urandom, $urandom, pick_value(), $urandom);
    else if (r < 82) send(drl_pkg::CMD_RD_WEIGHT, $urandom, $urandom, 16'($urandom), $urandom);
    else if (r < 87) send(drl_pkg::CMD_RD_BIAS, $urandom, $urandom, 16'($urandom), $urandom);
    else if (r < 92) send(drl_pkg::CMD_UPDATE, $urandom, $urandom, 16'($urandom), $urandom);
    else if (r < 95) send(drl_pkg::CMD_ZERO_GRAD, $urandom, $urandom, 16'($urandom), $urandom);
    else if (r < 98) send(drl_pkg::CMD_FWD_ELEM, $urandom, $urandom, pick_value(), 1'b0);
    else send(drl_pkg::CMD_BWD_ELEM, $urandom, $urandom, pick_value(), 1'b0);
  endtask

  // APB write: setup cycle, then access cycle; pready is always high.
  task automatic reg_write(drl_pkg::reg_t idx, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= drl_pkg::PADDR_W'({idx, 2'b00});
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      drl_pkg::REG_LR: sb.rate = v[15:0];
      drl_pkg::REG_IN_CNT: sb.in_reg = v[4:0];
      default: sb.out_reg = v[4:0];
    endcase
  endtask

  // Lets every result drain and any silent command finish.
  task automatic settle();
    if (in_ch.valid) in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic [15:0] lr, logic [4:0] ni, logic [4:0] no);
    settle();
    reg_write(drl_pkg::REG_LR, {16'd0, lr});
    reg_write(drl_pkg::REG_IN_CNT, {27'd0, ni});
    reg_write(drl_pkg::REG_OUT_CNT, {27'd0, no});
  endtask

  // Result side: one random stall per result, ready kept high across
  // back-to-back results when no stall is drawn.
  initial begin
    int gap;
    @(negedge rst);
    @(posedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      sb.check_result(out_ch.data);
    end
  end

  initial begin
    sb = new();
    sent = 0;
    no_gaps = 1'b0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Load every weight, bias and input once so that no store is ever read
    // before it holds a value; the reset counts of 16 cover every entry.
    no_gaps = 1'b1;
    for (int i = 0; i < 16; i++) begin
      send(drl_pkg::CMD_WR_BIAS, i, 0, pick_value(), 1'b0);
      for (int j = 0; j < 16; j++) send(drl_pkg::CMD_WR_WEIGHT, i, j, pick_value(), 1'b0);
    end
    send_forward_vector();
    no_gaps = 1'b0;
    sent = 0;

    // Directed part: field extremes, every command and saturation.
    send(drl_pkg::CMD_WR_WEIGHT, 15, 15, 16'h7FFF, 1'b1);
    send(drl_pkg::CMD_RD_WEIGHT, 15, 15, 16'hFFFF, 1'b0);
    send(drl_pkg::CMD_WR_BIAS, 0, 15, 16'h8000, 1'b1);
    send(drl_pkg::CMD_RD_BIAS, 0, 15, 16'h0000, 1'b1);
    send(drl_pkg::CMD_WR_BIAS, 15, 0, 16'h7FFF, 1'b0);
    send(drl_pkg::CMD_FWD_ELEM, 0, 15, 16'h8000, 1'b0);
    send(drl_pkg::CMD_FWD_ELEM, 15, 0, 16'h7FFF, 1'b1);
    send(drl_pkg::CMD_BWD_ELEM, 15, 0, 16'h7FFF, 1'b0);
    send(drl_pkg::CMD_BWD_ELEM, 0, 15, 16'h8000, 1'b0);
    send(drl_pkg::CMD_BWD_ELEM, 3, 3, 16'h0100, 1'b1);
    send(drl_pkg::CMD_UPDATE, 0, 0, 16'h0000, 1'b1);
    send(drl_pkg::CMD_RD_WEIGHT, 0, 0, 16'h0000, 1'b0);
    send(drl_pkg::CMD_RD_BIAS, 15, 0, 16'h0000, 1'b0);
    send(drl_pkg::CMD_ZERO_GRAD, 15, 15, 16'hFFFF, 1'b1);
    send(drl_pkg::CMD_UPDATE, 15, 15, 16'hFFFF, 1'b0);
    send(drl_pkg::CMD_RD_BIAS, 15, 15, 16'h0000, 1'b1);

    // Several register settings: reset values, counts of zero and above the
    // maximum (taken as one and sixteen), full-scale and zero rates.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: configure(16'd655, 5'd16, 5'd16);
        1: configure(16'hFFFF, 5'd0, 5'd31);
        2: configure(16'd0, 5'd31, 5'd1);
        3: configure(16'($urandom_range(256, 8191)), 5'($urandom_range(1, 16)),
                     5'($urandom_range(1, 16)));
        default: configure(16'($urandom), 5'd16, 5'd16);
      endcase
      // A zero-grad right after a change keeps the update steps in range.
      if (phase == 1) send(drl_pkg::CMD_ZERO_GRAD, 0, 0, 16'h0000, 1'b0);
      no_gaps = (phase == 3);
      while (sent < 16 + (phase + 1) * 50) send_random();
    end
    no_gaps = 1'b0;

    settle();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("dense_relu_layer_train regression: pass");
    end else begin
      $display("dense_relu_layer_train regression: fail");
    end
    $finish;
  end
endmodule

// File: files.f
hdl/drl_pkg.sv
hdl/drl_if.sv
hdl/drl_mac.sv
hdl/dense_relu_layer_train.sv
hdl/drl_chk.sv
tb/dense_relu_layer_train_tb.sv
